// File: rtl/assert_macros.svh
// Shared assertion macros for the checker files.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define ASSERT_NOW(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("same-cycle check failed");

// Next-cycle implication, disabled while reset is asserted.
`define ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("next-cycle check failed");

`endif

// File: rtl/crp_pkg.sv
`default_nettype none

package crp_pkg;

  localparam int unsigned DataW = 32;
  localparam int unsigned GainW = 31;
  localparam int unsigned AlphaW = 17;
  localparam int unsigned StepW = 24;
  localparam int unsigned PcW = 5;
  localparam int unsigned CfgIdxW = 3;

  localparam logic [StepW-1:0] MIN_STEP = 24'd16;

  localparam logic signed [DataW-1:0] DATA_MAX = 32'sh7FFF_FFFF;
  localparam logic signed [DataW-1:0] DATA_MIN = 32'sh8000_0000;

  // Configuration register indexes
  localparam logic [CfgIdxW-1:0] CFG_ATT_GAIN = 3'd0;
  localparam logic [CfgIdxW-1:0] CFG_PROP_GAIN = 3'd1;
  localparam logic [CfgIdxW-1:0] CFG_INTEG_GAIN = 3'd2;
  localparam logic [CfgIdxW-1:0] CFG_DERIV_GAIN = 3'd3;
  localparam logic [CfgIdxW-1:0] CFG_INTEG_LIMIT = 3'd4;
  localparam logic [CfgIdxW-1:0] CFG_FILTER_ALPHA = 3'd5;
  localparam logic [CfgIdxW-1:0] CFG_DRIVE_LIMIT = 3'd6;

  // Program labels
  localparam logic [PcW-1:0] PC_IDLE = 5'd0;
  localparam logic [PcW-1:0] PC_SKIP_D = 5'd22;

  typedef enum logic [3:0] {
    OP_NOP,
    OP_IN,
    OP_MUL,
    OP_SH16,
    OP_SH24,
    OP_ADD,
    OP_SUB,
    OP_CLAMP,
    OP_DIV,
    OP_OUT
  } crp_op_e;

  typedef enum logic [4:0] {
    SRC_ZERO,
    SRC_ATT,
    SRC_RATE,
    SRC_DT,
    SRC_ERR,
    SRC_ISUM,
    SRC_LAST,
    SRC_FS,
    SRC_T0,
    SRC_T1,
    SRC_T2,
    SRC_KATT,
    SRC_KP,
    SRC_KI,
    SRC_KD,
    SRC_ALPHA,
    SRC_ILIM,
    SRC_OLIM
  } crp_src_e;

  typedef enum logic [2:0] {
    DST_NONE,
    DST_ERR,
    DST_ISUM,
    DST_LAST,
    DST_FS,
    DST_T0,
    DST_T1,
    DST_T2
  } crp_dst_e;

  typedef enum logic [1:0] {
    JMP_NONE,
    JMP_SHORT,
    JMP_ALWAYS
  } crp_jmp_e;

  typedef struct packed {
    crp_op_e            op;
    crp_src_e           src_a;
    crp_src_e           src_b;
    crp_dst_e           dst;
    crp_jmp_e           jmp;
    logic [PcW-1:0]     target;
  } crp_ctrl_t;

  typedef struct packed {
    logic stall;
    logic is_short;
  } crp_status_t;

  typedef struct packed {
    logic [GainW-1:0]  att_gain;
    logic [GainW-1:0]  prop_gain;
    logic [GainW-1:0]  integ_gain;
    logic [GainW-1:0]  deriv_gain;
    logic [GainW-1:0]  integ_limit;
    logic [AlphaW-1:0] filter_alpha;
    logic [GainW-1:0]  drive_limit;
  } crp_cfg_t;

  function automatic crp_ctrl_t crp_word(crp_op_e op, crp_src_e a, crp_src_e b,
                                         crp_dst_e dst, crp_jmp_e jmp,
                                         logic [PcW-1:0] target);
    crp_ctrl_t w;
    w.op = op;
    w.src_a = a;
    w.src_b = b;
    w.dst = dst;
    w.jmp = jmp;
    w.target = target;
    return w;
  endfunction

  // Control store: one word per step of the per-item program
  function automatic crp_ctrl_t crp_ucode(logic [PcW-1:0] pc);
    crp_ctrl_t w;
    case (pc)
      5'd0:  w = crp_word(OP_IN, SRC_ZERO, SRC_ZERO, DST_NONE, JMP_NONE, PC_IDLE);
      5'd1:  w = crp_word(OP_MUL, SRC_KATT, SRC_ATT, DST_NONE, JMP_NONE, PC_IDLE);
      5'd2:  w = crp_word(OP_SH16, SRC_ZERO, SRC_ZERO, DST_T0, JMP_NONE, PC_IDLE);
      5'd3:  w = crp_word(OP_SUB, SRC_T0, SRC_RATE, DST_ERR, JMP_NONE, PC_IDLE);
      5'd4:  w = crp_word(OP_MUL, SRC_KP, SRC_ERR, DST_NONE, JMP_NONE, PC_IDLE);
      5'd5:  w = crp_word(OP_SH16, SRC_ZERO, SRC_ZERO, DST_T1, JMP_NONE, PC_IDLE);
      5'd6:  w = crp_word(OP_MUL, SRC_ERR, SRC_DT, DST_NONE, JMP_NONE, PC_IDLE);
      5'd7:  w = crp_word(OP_SH24, SRC_ZERO, SRC_ZERO, DST_T0, JMP_NONE, PC_IDLE);
      5'd8:  w = crp_word(OP_ADD, SRC_ISUM, SRC_T0, DST_ISUM, JMP_NONE, PC_IDLE);
      5'd9:  w = crp_word(OP_CLAMP, SRC_ISUM, SRC_ILIM, DST_ISUM, JMP_NONE, PC_IDLE);
      5'd10: w = crp_word(OP_MUL, SRC_KI, SRC_ISUM, DST_NONE, JMP_NONE, PC_IDLE);
      5'd11: w = crp_word(OP_SH16, SRC_ZERO, SRC_ZERO, DST_T2, JMP_NONE, PC_IDLE);
      5'd12: w = crp_word(OP_ADD, SRC_T1, SRC_T2, DST_T1, JMP_NONE, PC_IDLE);
      5'd13: w = crp_word(OP_SUB, SRC_ERR, SRC_LAST, DST_T0, JMP_SHORT, PC_SKIP_D);
      5'd14: w = crp_word(OP_DIV, SRC_T0, SRC_DT, DST_T0, JMP_NONE, PC_IDLE);
      5'd15: w = crp_word(OP_SUB, SRC_T0, SRC_FS, DST_T0, JMP_NONE, PC_IDLE);
      5'd16: w = crp_word(OP_MUL, SRC_ALPHA, SRC_T0, DST_NONE, JMP_NONE, PC_IDLE);
      5'd17: w = crp_word(OP_SH16, SRC_ZERO, SRC_ZERO, DST_T0, JMP_NONE, PC_IDLE);
      5'd18: w = crp_word(OP_ADD, SRC_FS, SRC_T0, DST_FS, JMP_NONE, PC_IDLE);
      5'd19: w = crp_word(OP_MUL, SRC_KD, SRC_FS, DST_NONE, JMP_NONE, PC_IDLE);
      5'd20: w = crp_word(OP_SH16, SRC_ZERO, SRC_ZERO, DST_T2, JMP_NONE, PC_IDLE);
      5'd21: w = crp_word(OP_ADD, SRC_T1, SRC_T2, DST_T1, JMP_NONE, PC_IDLE);
      5'd22: w = crp_word(OP_ADD, SRC_ERR, SRC_ZERO, DST_LAST, JMP_NONE, PC_IDLE);
      5'd23: w = crp_word(OP_CLAMP, SRC_T1, SRC_OLIM, DST_T1, JMP_NONE, PC_IDLE);
      5'd24: w = crp_word(OP_OUT, SRC_T1, SRC_ZERO, DST_NONE, JMP_ALWAYS, PC_IDLE);
      default: w = crp_word(OP_NOP, SRC_ZERO, SRC_ZERO, DST_NONE, JMP_ALWAYS, PC_IDLE);
    endcase
    return w;
  endfunction

  function automatic logic signed [DataW-1:0] crp_sat_add(logic signed [DataW-1:0] a,
                                                          logic signed [DataW-1:0] b);
    logic signed [DataW:0] s;
    s = {a[DataW-1], a} + {b[DataW-1], b};
    if (s[DataW] != s[DataW-1]) begin
      return s[DataW] ? DATA_MIN : DATA_MAX;
    end
    return s[DataW-1:0];
  endfunction

  function automatic logic signed [DataW-1:0] crp_sat_sub(logic signed [DataW-1:0] a,
                                                          logic signed [DataW-1:0] b);
    logic signed [DataW:0] s;
    s = {a[DataW-1], a} - {b[DataW-1], b};
    if (s[DataW] != s[DataW-1]) begin
      return s[DataW] ? DATA_MIN : DATA_MAX;
    end
    return s[DataW-1:0];
  endfunction

  // Saturate a shifted product back to the data range
  function automatic logic signed [DataW-1:0] crp_sat_wide(logic signed [2*DataW-1:0] v);
    if (v > $signed({{DataW{1'b0}}, DATA_MAX})) begin
      return DATA_MAX;
    end
    if (v < $signed({{DataW{1'b1}}, DATA_MIN})) begin
      return DATA_MIN;
    end
    return v[DataW-1:0];
  endfunction

  // Symmetric clamp against a non-negative limit
  function automatic logic signed [DataW-1:0] crp_clamp(logic signed [DataW-1:0] a,
                                                        logic signed [DataW-1:0] lim);
    logic signed [DataW-1:0] nlim;
    nlim = -lim;
    if (a > lim) begin
      return lim;
    end
    if (a < nlim) begin
      return nlim;
    end
    return a;
  endfunction

endpackage

`default_nettype wire

// File: rtl/crp_seq.sv
`default_nettype none

module crp_seq (
  input  wire                       clk_i,
  input  wire                       rst_ni,
  input  wire crp_pkg::crp_status_t status_i,
  output crp_pkg::crp_ctrl_t        ctrl_o
);

  logic [crp_pkg::PcW-1:0] pc_q, pc_d;
  crp_pkg::crp_ctrl_t      word;

  // Fetch the control word for the current step
  always_comb begin
    word = crp_pkg::crp_ucode(pc_q);
  end

  assign ctrl_o = word;

  // Hold on stall, take a jump when its condition holds, else advance
  always_comb begin
    pc_d = pc_q + 5'd1;
    if (status_i.stall) begin
      pc_d = pc_q;
    end else if (word.jmp == crp_pkg::JMP_ALWAYS) begin
      pc_d = word.target;
    end else if (word.jmp == crp_pkg::JMP_SHORT && status_i.is_short) begin
      pc_d = word.target;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pc_q <= crp_pkg::PC_IDLE;
    end else begin
      pc_q <= pc_d;
    end
  end

endmodule

`default_nettype wire

// File: rtl/crp_div.sv
`default_nettype none

module crp_div (
  input  wire                                    clk_i,
  input  wire                                    rst_ni,
  input  wire                                    start_i,
  input  wire logic signed [crp_pkg::DataW-1:0]  diff_i,
  input  wire logic [crp_pkg::StepW-1:0]         dt_i,
  output logic                                   done_o,
  output logic signed [crp_pkg::DataW-1:0]       slope_o
);

  logic                            busy_q, busy_d;
  logic                            done_q, done_d;
  logic [3:0]                      cnt_q, cnt_d;
  logic [crp_pkg::StepW-1:0]       rem_q, rem_d;
  logic [crp_pkg::DataW-1:0]       quo_q, quo_d;
  logic                            neg_q, neg_d;
  logic                            ovf_q, ovf_d;
  logic [crp_pkg::DataW-1:0]       mag;
  logic [crp_pkg::StepW-1:0]       r_it;
  logic [crp_pkg::DataW-1:0]       q_it;
  logic [crp_pkg::StepW:0]         trial;

  assign mag = diff_i[crp_pkg::DataW-1] ? (~diff_i + 32'd1) : diff_i;

  // Two restoring quotient bits per cycle
  always_comb begin
    r_it = rem_q;
    q_it = quo_q;
    trial = '0;
    for (int k = 0; k < 2; k++) begin
      trial = {r_it, q_it[crp_pkg::DataW-1]};
      q_it = {q_it[crp_pkg::DataW-2:0], 1'b0};
      if (trial >= {1'b0, dt_i}) begin
        // trial is below twice the divisor, so the low bits hold the difference
        r_it = trial[crp_pkg::StepW-1:0] - dt_i;
        q_it[0] = 1'b1;
      end else begin
        r_it = trial[crp_pkg::StepW-1:0];
      end
    end
  end

  // Load on start: upper dividend word seeds the remainder; then iterate while busy
  always_comb begin
    busy_d = busy_q;
    done_d = 1'b0;
    cnt_d = cnt_q;
    rem_d = rem_q;
    quo_d = quo_q;
    neg_d = neg_q;
    ovf_d = ovf_q;
    if (start_i && !busy_q) begin
      busy_d = 1'b1;
      cnt_d = '0;
      neg_d = diff_i[crp_pkg::DataW-1];
      rem_d = mag[crp_pkg::DataW-1:8];
      quo_d = {mag[7:0], 24'd0};
      ovf_d = (mag[crp_pkg::DataW-1:8] >= dt_i);
    end else if (busy_q) begin
      rem_d = r_it;
      quo_d = q_it;
      cnt_d = cnt_q + 4'd1;
      if (cnt_q == 4'd15) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q <= rem_d;
    quo_q <= quo_d;
    neg_q <= neg_d;
    ovf_q <= ovf_d;
  end

  // Apply the sign and saturate the quotient
  always_comb begin
    if (neg_q) begin
      if (ovf_q || quo_q > 32'h8000_0000) begin
        slope_o = crp_pkg::DATA_MIN;
      end else begin
        slope_o = $signed(32'd0 - quo_q);
      end
    end else begin
      if (ovf_q || quo_q[crp_pkg::DataW-1]) begin
        slope_o = crp_pkg::DATA_MAX;
      end else begin
        slope_o = $signed(quo_q);
      end
    end
  end

  assign done_o = done_q;

endmodule

`default_nettype wire

// File: rtl/crp_dpath.sv
`default_nettype none

module crp_dpath (
  input  wire                               clk_i,
  input  wire                               rst_ni,
  input  wire crp_pkg::crp_ctrl_t           ctrl_i,
  input  wire crp_pkg::crp_cfg_t            cfg_i,
  output crp_pkg::crp_status_t              status_o,
  input  wire                               in_valid_i,
  output logic                              in_ready_o,
  input  wire logic [87:0]                  in_data_i,
  output logic                              out_valid_o,
  input  wire                               out_ready_i,
  output logic [crp_pkg::DataW-1:0]         out_data_o
);

  logic signed [crp_pkg::DataW-1:0]   att_q, rate_q;
  logic [crp_pkg::StepW-1:0]          dt_q;
  logic signed [crp_pkg::DataW-1:0]   err_q, isum_q, last_q, fs_q;
  logic signed [crp_pkg::DataW-1:0]   t0_q, t1_q, t2_q;
  logic signed [2*crp_pkg::DataW-1:0] prod_q;
  logic                               out_valid_q;
  logic [crp_pkg::DataW-1:0]          out_q;
  logic signed [crp_pkg::DataW-1:0]   a_val, b_val, res;
  logic                               wr_en, stall, in_beat, out_load, slot_free;
  logic                               div_done;
  logic signed [crp_pkg::DataW-1:0]   div_slope;

  function automatic logic signed [crp_pkg::DataW-1:0] pick(crp_pkg::crp_src_e s,
      logic signed [crp_pkg::DataW-1:0] att, logic signed [crp_pkg::DataW-1:0] rate,
      logic [crp_pkg::StepW-1:0] dt, logic signed [crp_pkg::DataW-1:0] err,
      logic signed [crp_pkg::DataW-1:0] isum, logic signed [crp_pkg::DataW-1:0] last,
      logic signed [crp_pkg::DataW-1:0] fs, logic signed [crp_pkg::DataW-1:0] t0,
      logic signed [crp_pkg::DataW-1:0] t1, logic signed [crp_pkg::DataW-1:0] t2,
      crp_pkg::crp_cfg_t cfg);
    case (s)
      crp_pkg::SRC_ZERO:  return '0;
      crp_pkg::SRC_ATT:   return att;
      crp_pkg::SRC_RATE:  return rate;
      crp_pkg::SRC_DT:    return $signed({8'd0, dt});
      crp_pkg::SRC_ERR:   return err;
      crp_pkg::SRC_ISUM:  return isum;
      crp_pkg::SRC_LAST:  return last;
      crp_pkg::SRC_FS:    return fs;
      crp_pkg::SRC_T0:    return t0;
      crp_pkg::SRC_T1:    return t1;
      crp_pkg::SRC_T2:    return t2;
      crp_pkg::SRC_KATT:  return $signed({1'b0, cfg.att_gain});
      crp_pkg::SRC_KP:    return $signed({1'b0, cfg.prop_gain});
      crp_pkg::SRC_KI:    return $signed({1'b0, cfg.integ_gain});
      crp_pkg::SRC_KD:    return $signed({1'b0, cfg.deriv_gain});
      crp_pkg::SRC_ALPHA: return $signed({15'd0, cfg.filter_alpha});
      crp_pkg::SRC_ILIM:  return $signed({1'b0, cfg.integ_limit});
      crp_pkg::SRC_OLIM:  return $signed({1'b0, cfg.drive_limit});
      default:            return '0;
    endcase
  endfunction

  // Select the operands named by the control word
  always_comb begin
    a_val = pick(ctrl_i.src_a, att_q, rate_q, dt_q, err_q, isum_q, last_q, fs_q,
                 t0_q, t1_q, t2_q, cfg_i);
    b_val = pick(ctrl_i.src_b, att_q, rate_q, dt_q, err_q, isum_q, last_q, fs_q,
                 t0_q, t1_q, t2_q, cfg_i);
  end

  crp_div u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (ctrl_i.op == crp_pkg::OP_DIV && !div_done),
    .diff_i  (a_val),
    .dt_i    (dt_q),
    .done_o  (div_done),
    .slope_o (div_slope)
  );

  // Compute the step result
  always_comb begin
    case (ctrl_i.op)
      crp_pkg::OP_SH16:  res = crp_pkg::crp_sat_wide(prod_q >>> 16);
      crp_pkg::OP_SH24:  res = crp_pkg::crp_sat_wide(prod_q >>> 24);
      crp_pkg::OP_ADD:   res = crp_pkg::crp_sat_add(a_val, b_val);
      crp_pkg::OP_SUB:   res = crp_pkg::crp_sat_sub(a_val, b_val);
      crp_pkg::OP_CLAMP: res = crp_pkg::crp_clamp(a_val, b_val);
      crp_pkg::OP_DIV:   res = div_slope;
      default:           res = '0;
    endcase
  end

  // Stall on a missing input beat, a busy divider or a full output slot
  assign slot_free = !out_valid_q || out_ready_i;
  assign in_ready_o = (ctrl_i.op == crp_pkg::OP_IN);
  assign in_beat = in_ready_o && in_valid_i;
  assign out_load = (ctrl_i.op == crp_pkg::OP_OUT) && slot_free;

  always_comb begin
    case (ctrl_i.op)
      crp_pkg::OP_IN:  stall = !in_valid_i;
      crp_pkg::OP_DIV: stall = !div_done;
      crp_pkg::OP_OUT: stall = !slot_free;
      default:         stall = 1'b0;
    endcase
  end

  assign wr_en = !stall && (ctrl_i.dst != crp_pkg::DST_NONE) &&
                 (ctrl_i.op inside {crp_pkg::OP_SH16, crp_pkg::OP_SH24, crp_pkg::OP_ADD,
                                    crp_pkg::OP_SUB, crp_pkg::OP_CLAMP, crp_pkg::OP_DIV});

  assign status_o.stall = stall;
  assign status_o.is_short = (dt_q <= crp_pkg::MIN_STEP);

  // Latch the input beat and the working registers
  always_ff @(posedge clk_i) begin
    if (in_beat) begin
      att_q <= $signed(in_data_i[31:0]);
      rate_q <= $signed(in_data_i[63:32]);
      dt_q <= in_data_i[87:64];
    end
    if (ctrl_i.op == crp_pkg::OP_MUL) begin
      prod_q <= a_val * b_val;
    end
    if (wr_en && ctrl_i.dst == crp_pkg::DST_ERR) begin
      err_q <= res;
    end
    if (wr_en && ctrl_i.dst == crp_pkg::DST_T0) begin
      t0_q <= res;
    end
    if (wr_en && ctrl_i.dst == crp_pkg::DST_T1) begin
      t1_q <= res;
    end
    if (wr_en && ctrl_i.dst == crp_pkg::DST_T2) begin
      t2_q <= res;
    end
    if (out_load) begin
      out_q <= a_val;
    end
  end

  // Controller state survives between items
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      isum_q <= '0;
      last_q <= '0;
      fs_q <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (wr_en && ctrl_i.dst == crp_pkg::DST_ISUM) begin
        isum_q <= res;
      end
      if (wr_en && ctrl_i.dst == crp_pkg::DST_LAST) begin
        last_q <= res;
      end
      if (wr_en && ctrl_i.dst == crp_pkg::DST_FS) begin
        fs_q <= res;
      end
      if (out_load) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o = out_q;

endmodule

`default_nettype wire

// File: rtl/cascade_rate_pid_axis.sv
// One axis of a cascade attitude/rate controller in signed Q16.16.
// Input stream: one beat per control step carries the attitude error, the
// measured body rate and the step time (2^-24 s units). Output stream: one
// beat per input beat carries the clamped drive value.
// Configuration: a separate write channel (index, data); it is always ready
// and should only be written while no beat is in flight.
// Structure: a microcoded sequencer runs a 25-step program over one
// shared 32x32 multiplier and a 2-bit-per-cycle divider. When the step time
// is 16 or less, the derivative steps are skipped. The divider loads its
// operands, then runs 16 two-bit steps. One item is worked on at a time;
// the next input beat can be taken from the cycle after the result enters
// the output register.
// Reset: gains clear to zero, limits to full scale, alpha to one, and the
// integral, last error and filtered slope to zero; the output is empty.
// Stall: a result held by the receiver stays in the output register; a new
// item is still accepted and computed, then waits at the output step.
`default_nettype none

module cascade_rate_pid_axis (
  input  wire                              clk_i,
  input  wire                              rst_ni,
  // tdata: attitude_error[31:0], body_rate[63:32], step_time[87:64]
  input  wire                              s_axis_tvalid,
  output logic                             s_axis_tready,
  input  wire logic [87:0]                 s_axis_tdata,
  // tdata: drive[31:0]
  output logic                             m_axis_tvalid,
  input  wire                              m_axis_tready,
  output logic [31:0]                      m_axis_tdata,
  input  wire                              cfg_valid_i,
  output logic                             cfg_ready_o,
  input  wire logic [crp_pkg::CfgIdxW-1:0] cfg_index_i,
  input  wire logic [crp_pkg::GainW-1:0]   cfg_data_i
);

  crp_pkg::crp_cfg_t    cfg_q;
  crp_pkg::crp_ctrl_t   ctrl;
  crp_pkg::crp_status_t status;

  assign cfg_ready_o = 1'b1;

  // Write one register per beat; drop unknown indexes
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.att_gain <= '0;
      cfg_q.prop_gain <= '0;
      cfg_q.integ_gain <= '0;
      cfg_q.deriv_gain <= '0;
      cfg_q.integ_limit <= 31'h7FFF_FFFF;
      cfg_q.filter_alpha <= 17'h1_0000;
      cfg_q.drive_limit <= 31'h7FFF_FFFF;
    end else if (cfg_valid_i) begin
      case (cfg_index_i)
        crp_pkg::CFG_ATT_GAIN:     cfg_q.att_gain <= cfg_data_i;
        crp_pkg::CFG_PROP_GAIN:    cfg_q.prop_gain <= cfg_data_i;
        crp_pkg::CFG_INTEG_GAIN:   cfg_q.integ_gain <= cfg_data_i;
        crp_pkg::CFG_DERIV_GAIN:   cfg_q.deriv_gain <= cfg_data_i;
        crp_pkg::CFG_INTEG_LIMIT:  cfg_q.integ_limit <= cfg_data_i;
        crp_pkg::CFG_FILTER_ALPHA: cfg_q.filter_alpha <= cfg_data_i[crp_pkg::AlphaW-1:0];
        crp_pkg::CFG_DRIVE_LIMIT:  cfg_q.drive_limit <= cfg_data_i;
        default: ;
      endcase
    end
  end

  crp_seq u_seq (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .status_i (status),
    .ctrl_o   (ctrl)
  );

  crp_dpath u_dpath (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .ctrl_i      (ctrl),
    .cfg_i       (cfg_q),
    .status_o    (status),
    .in_valid_i  (s_axis_tvalid),
    .in_ready_o  (s_axis_tready),
    .in_data_i   (s_axis_tdata),
    .out_valid_o (m_axis_tvalid),
    .out_ready_i (m_axis_tready),
    .out_data_o  (m_axis_tdata)
  );

endmodule

`default_nettype wire

// File: rtl/crp_checker.sv
`default_nettype none
`include "assert_macros.svh"

module crp_checker (
  input  wire                              clk_i,
  input  wire                              rst_ni,
  input  wire                              s_axis_tvalid,
  input  wire                              s_axis_tready,
  input  wire logic [87:0]                 s_axis_tdata,
  input  wire                              m_axis_tvalid,
  input  wire                              m_axis_tready,
  input  wire logic [31:0]                 m_axis_tdata,
  input  wire                              cfg_valid_i,
  input  wire                              cfg_ready_o,
  input  wire logic [crp_pkg::CfgIdxW-1:0] cfg_index_i,
  input  wire logic [crp_pkg::GainW-1:0]   cfg_data_i
);

  logic in_beat;
  logic unused_ok;

  assign in_beat = s_axis_tvalid && s_axis_tready;
  assign unused_ok = ^{s_axis_tdata, cfg_valid_i, cfg_ready_o, cfg_index_i, cfg_data_i};

  // One item at a time: input closes right after a beat
  `ASSERT_NEXT(a_in_closes, clk_i, rst_ni, in_beat, !s_axis_tready)

  // A stalled result beat holds its value
  `ASSERT_NEXT(a_out_hold, clk_i, rst_ni, m_axis_tvalid && !m_axis_tready,
               m_axis_tvalid && $stable(m_axis_tdata))

  // A result never appears the cycle after an input beat
  `ASSERT_NOW(a_no_instant_out, clk_i, rst_ni, $rose(m_axis_tvalid), !$past(in_beat))

endmodule

bind cascade_rate_pid_axis crp_checker u_crp_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .s_axis_tvalid (s_axis_tvalid),
  .s_axis_tready (s_axis_tready),
  .s_axis_tdata  (s_axis_tdata),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata),
  .cfg_valid_i   (cfg_valid_i),
  .cfg_ready_o   (cfg_ready_o),
  .cfg_index_i   (cfg_index_i),
  .cfg_data_i    (cfg_data_i)
);

`default_nettype wire

// File: dv/testbench.sv
`timescale 1ns / 1ps

module testbench;
  import crp_pkg::*;

  localparam int FRAC_SHIFT = 16;
  localparam int STEP_SHIFT = 24;
  localparam int ITEMS_TOTAL = 1750;
  localparam int LAST_STRETCH = 200;
  localparam int HOLD_CYCLES = 300;
  localparam int SETTLE_CYCLES = 100;
  localparam logic [CfgIdxW-1:0] CFG_UNUSED = 3'd7;
  localparam logic [GainW-1:0] GAIN_MAX = 31'h7FFF_FFFF;
  localparam longint Q_HI = longint'(DATA_MAX);
  localparam longint Q_LO = longint'(DATA_MIN);
  localparam logic signed [DataW-1:0] ONE_Q = 32'sh0001_0000;

  typedef struct {
    logic signed [DataW-1:0] att_err;
    logic signed [DataW-1:0] gyro;
    logic [StepW-1:0]        dt;
  } rate_step_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic s_axis_tvalid = 1'b0;
  logic s_axis_tready;
  logic [87:0] s_axis_tdata = '0;
  logic m_axis_tvalid;
  logic m_axis_tready = 1'b0;
  logic [31:0] m_axis_tdata;
  logic cfg_valid_i = 1'b0;
  logic cfg_ready_o;
  logic [CfgIdxW-1:0] cfg_index_i = '0;
  logic [GainW-1:0] cfg_data_i = '0;

  // Controller settings as the block should hold them
  longint att_k = 0;
  longint prop_k = 0;
  longint int_k = 0;
  longint der_k = 0;
  longint int_lim = Q_HI;
  longint alpha_k = 65536;
  longint drv_lim = Q_HI;

  // Controller state as the block should hold it
  longint integ_acc = 0;
  longint prev_rate_err = 0;
  longint slope_lp = 0;

  rate_step_t step_q[$];
  logic [31:0] expected_drive[$];
  rate_step_t offered;
  logic [31:0] want_drive;
  int src_gap = 0;
  int sink_gap = 0;
  bit idle_on = 1'b1;
  bit hold_go = 1'b0;
  logic sink_blocked = 1'b0;
  int steps_queued = 0;
  int steps_taken = 0;
  int drives_seen = 0;
  int bad_drive = 0;
  int settings_used = 1;

  cascade_rate_pid_axis dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .cfg_valid_i   (cfg_valid_i),
    .cfg_ready_o   (cfg_ready_o),
    .cfg_index_i   (cfg_index_i),
    .cfg_data_i    (cfg_data_i)
  );

  always begin
    #2 clk_i = 1'b1;
    #2 clk_i = 1'b0;
  end

  // Fixed-point helpers: saturate to the data range, floor product, step divide
  function automatic longint clip_q(longint v);
    if (v > Q_HI) begin
      return Q_HI;
    end
    if (v < Q_LO) begin
      return Q_LO;
    end
    return v;
  endfunction

  function automatic longint add_q(longint a, longint b);
    return clip_q(a + b);
  endfunction

  function automatic longint sub_q(longint a, longint b);
    return clip_q(a - b);
  endfunction

  function automatic longint mul_q(longint a, longint b, int sh);
    return clip_q((a * b) >>> sh);
  endfunction

  // Error difference over the step time, rounded toward zero
  function automatic longint slope_q(longint diff, longint dt);
    longint m;
    longint q;
    m = (diff < 0) ? -diff : diff;
    q = (m << STEP_SHIFT) / dt;
    return clip_q((diff < 0) ? -q : q);
  endfunction

  // Run one control step on the shadow state and return the drive
  function automatic logic [31:0] pid_step(rate_step_t s);
    longint dt;
    longint err;
    longint p_part;
    longint i_part;
    longint d_part;
    longint sum;
    dt = longint'(s.dt);
    err = sub_q(mul_q(att_k, longint'(s.att_err), FRAC_SHIFT), longint'(s.gyro));
    p_part = mul_q(prop_k, err, FRAC_SHIFT);
    integ_acc = add_q(integ_acc, mul_q(err, dt, STEP_SHIFT));
    if (integ_acc > int_lim) begin
      integ_acc = int_lim;
    end
    if (integ_acc < -int_lim) begin
      integ_acc = -int_lim;
    end
    i_part = mul_q(int_k, integ_acc, FRAC_SHIFT);
    d_part = 0;
    if (s.dt > MIN_STEP) begin
      slope_lp = add_q(slope_lp, mul_q(alpha_k,
                 sub_q(slope_q(sub_q(err, prev_rate_err), dt), slope_lp), FRAC_SHIFT));
      d_part = mul_q(der_k, slope_lp, FRAC_SHIFT);
    end
    prev_rate_err = err;
    sum = add_q(add_q(p_part, i_part), d_part);
    if (sum > drv_lim) begin
      sum = drv_lim;
    end
    if (sum < -drv_lim) begin
      sum = -drv_lim;
    end
    return sum[31:0];
  endfunction

  // Input driver: offer queued steps, with random idle bursts
  always @(posedge clk_i) begin
    if (!rst_ni) begin
      s_axis_tvalid <= 1'b0;
    end else begin
      if (s_axis_tvalid && s_axis_tready) begin
        expected_drive.push_back(pid_step(offered));
        steps_taken++;
      end
      if (!s_axis_tvalid || s_axis_tready) begin
        if (src_gap != 0) begin
          src_gap--;
          s_axis_tvalid <= 1'b0;
        end else if (idle_on && $urandom_range(0, 4) == 0) begin
          src_gap = $urandom_range(0, 9);
          s_axis_tvalid <= 1'b0;
        end else if (step_q.size() != 0) begin
          offered = step_q.pop_front();
          s_axis_tdata <= {offered.dt, offered.gyro, offered.att_err};
          s_axis_tvalid <= 1'b1;
        end else begin
          s_axis_tvalid <= 1'b0;
        end
      end
    end
  end

  // Output monitor: check each drive beat, then pick the next ready value
  always @(posedge clk_i) begin
    if (!rst_ni) begin
      m_axis_tready <= 1'b0;
    end else begin
      if (m_axis_tvalid && m_axis_tready) begin
        drives_seen++;
        if (expected_drive.size() == 0) begin
          bad_drive++;
          if (bad_drive <= 10) begin
            $display("%0t: drive beat 0x%08h with no step pending", $realtime, m_axis_tdata);
          end
        end else begin
          want_drive = expected_drive.pop_front();
          if (m_axis_tdata !== want_drive) begin
            bad_drive++;
            if (bad_drive <= 10) begin
              $display("%0t: drive mismatch, expected 0x%08h (%0d), got 0x%08h (%0d)",
                       $realtime, want_drive, $signed(want_drive),
                       m_axis_tdata, $signed(m_axis_tdata));
            end
          end
        end
      end
      if (sink_blocked) begin
        m_axis_tready <= 1'b0;
      end else if (sink_gap != 0) begin
        sink_gap--;
        m_axis_tready <= 1'b0;
      end else if (idle_on && $urandom_range(0, 5) == 0) begin
        sink_gap = $urandom_range(0, 9);
        m_axis_tready <= 1'b0;
      end else begin
        m_axis_tready <= 1'b1;
      end
    end
  end

  // Long receiver hold so the block backs up and stalls its input
  initial begin
    wait (hold_go);
    @(posedge clk_i);
    sink_blocked <= 1'b1;
    repeat (HOLD_CYCLES) @(posedge clk_i);
    sink_blocked <= 1'b0;
  end

  initial begin
    #4_000_000;
    $display("testbench NOT OK");
    $finish;
  end

  // Write one register and mirror it in the shadow settings
  task automatic write_reg(input logic [CfgIdxW-1:0] idx, input logic [GainW-1:0] val);
    @(posedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i <= val;
    do @(posedge clk_i); while (!cfg_ready_o);
    cfg_valid_i <= 1'b0;
    case (idx)
      CFG_ATT_GAIN:     att_k = longint'(val);
      CFG_PROP_GAIN:    prop_k = longint'(val);
      CFG_INTEG_GAIN:   int_k = longint'(val);
      CFG_DERIV_GAIN:   der_k = longint'(val);
      CFG_INTEG_LIMIT:  int_lim = longint'(val);
      CFG_FILTER_ALPHA: alpha_k = longint'(val[AlphaW-1:0]);
      CFG_DRIVE_LIMIT:  drv_lim = longint'(val);
      default: ;
    endcase
  endtask

  task automatic write_all(input logic [GainW-1:0] ka, input logic [GainW-1:0] kp,
                           input logic [GainW-1:0] ki, input logic [GainW-1:0] kd,
                           input logic [GainW-1:0] ilim, input logic [GainW-1:0] alpha,
                           input logic [GainW-1:0] dlim);
    write_reg(CFG_ATT_GAIN, ka);
    write_reg(CFG_PROP_GAIN, kp);
    write_reg(CFG_INTEG_GAIN, ki);
    write_reg(CFG_DERIV_GAIN, kd);
    write_reg(CFG_INTEG_LIMIT, ilim);
    write_reg(CFG_FILTER_ALPHA, alpha);
    write_reg(CFG_DRIVE_LIMIT, dlim);
    settings_used++;
    @(negedge clk_i);
  endtask

  task automatic push_step(input logic signed [DataW-1:0] att, input logic signed [DataW-1:0] rate,
                           input logic [StepW-1:0] dt);
    rate_step_t s;
    s.att_err = att;
    s.gyro = rate;
    s.dt = dt;
    step_q.push_back(s);
    steps_queued++;
  endtask

  // Hold until every queued step is taken and every drive has come back
  task automatic wait_idle();
    while (step_q.size() != 0 || s_axis_tvalid || expected_drive.size() != 0) begin
      @(negedge clk_i);
    end
  endtask

  function automatic logic [GainW-1:0] pick_gain();
    case ($urandom_range(0, 5))
      0: return '0;
      1: return GAIN_MAX;
      2, 3: return 31'($urandom_range(0, 32'h0008_0000));
      4: return 31'($urandom_range(0, 32'h0000_1000));
      default: return 31'($urandom());
    endcase
  endfunction

  function automatic logic [GainW-1:0] pick_limit();
    case ($urandom_range(0, 4))
      0: return '0;
      1: return GAIN_MAX;
      2: return 31'($urandom());
      default: return 31'($urandom_range(0, 32'h0064_0000));
    endcase
  endfunction

  // Upper data bits are dropped by the alpha register
  function automatic logic [GainW-1:0] pick_alpha();
    case ($urandom_range(0, 5))
      0: return '0;
      1: return 31'd65536;
      2: return 31'h1_FFFF;
      3: return 31'($urandom());
      default: return 31'($urandom_range(0, 65536));
    endcase
  endfunction

  function automatic logic signed [DataW-1:0] pick_value(int unsigned span);
    case ($urandom_range(0, 9))
      0: return $urandom();
      1: begin
        case ($urandom_range(0, 3))
          0: return DATA_MAX;
          1: return DATA_MIN;
          2: return '0;
          default: return -32'sd1;
        endcase
      end
      default: return 32'($urandom_range(0, 2 * span)) - 32'(span);
    endcase
  endfunction

  function automatic logic [StepW-1:0] pick_dt();
    case ($urandom_range(0, 7))
      0: return 24'($urandom_range(0, 16));
      1: return MIN_STEP + 24'd1;
      2: return 24'hFF_FFFF;
      3: return 24'($urandom());
      default: return 24'($urandom_range(8000, 40000));
    endcase
  endfunction

  task automatic random_phase(input int count);
    write_all(pick_gain(), pick_gain(), pick_gain(), pick_gain(),
              pick_limit(), pick_alpha(), pick_limit());
    if ($urandom_range(0, 2) == 0) begin
      write_reg(CFG_UNUSED, 31'($urandom()));
      @(negedge clk_i);
    end
    for (int k = 0; k < count; k++) begin
      push_step(pick_value(32'h0002_0000), pick_value(32'h0008_0000), pick_dt());
    end
  endtask

  initial begin
    int phase_no;
    int phase_len;
    phase_no = 0;
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // Reset settings: all gains zero, so the drive stays at zero
    push_step(DATA_MAX, DATA_MIN, MIN_STEP + 24'd1);
    push_step(DATA_MIN, DATA_MAX, 24'hFF_FFFF);
    wait_idle();

    // Moderate gains: field extremes, short steps and integral windup
    write_all(31'h4_0000, 31'h1_8000, 31'h8000, 31'h1999, 31'hA_0000, 31'h4000, 31'h14_0000);
    push_step('0, '0, 24'd16777);
    push_step(DATA_MAX, DATA_MIN, 24'd16777);
    push_step(DATA_MIN, DATA_MAX, 24'd16777);
    push_step(-32'sd1, 32'sd1, 24'd0);
    push_step(ONE_Q, '0, 24'd1);
    push_step(ONE_Q, '0, MIN_STEP);
    push_step(ONE_Q, 32'sh8000, MIN_STEP + 24'd1);
    push_step(ONE_Q, -ONE_Q, 24'hFF_FFFF);
    repeat (3) push_step(2 * ONE_Q, '0, 24'hFF_FFFF);
    push_step('0, DATA_MAX, MIN_STEP + 24'd1);
    push_step('0, DATA_MIN, MIN_STEP + 24'd1);
    push_step(-ONE_Q, '0, 24'd16777);
    push_step('0, '0, 24'd16777);
    wait_idle();

    // Full-scale gains and alpha above one, to drive the stages into saturation
    write_all(GAIN_MAX, GAIN_MAX, GAIN_MAX, GAIN_MAX, GAIN_MAX, 31'h1_FFFF, GAIN_MAX);
    push_step(DATA_MAX, '0, MIN_STEP + 24'd1);
    push_step(DATA_MIN, '0, MIN_STEP + 24'd1);
    push_step(32'sd1, -32'sd1, 24'hFF_FFFF);
    push_step('0, '0, MIN_STEP);
    push_step(-32'sd1, '0, MIN_STEP + 24'd1);
    wait_idle();

    // Zero limits pin integral and drive; unused index must be ignored
    write_reg(CFG_INTEG_LIMIT, '0);
    write_reg(CFG_DRIVE_LIMIT, '0);
    write_reg(CFG_UNUSED, GAIN_MAX);
    settings_used++;
    @(negedge clk_i);
    push_step(DATA_MAX, DATA_MIN, 24'hFF_FFFF);
    push_step(ONE_Q, '0, MIN_STEP + 24'd1);
    push_step('0, ONE_Q, 24'd0);
    wait_idle();

    // Random settings and steps, with a long output stall in one phase
    while (steps_queued < ITEMS_TOTAL - LAST_STRETCH) begin
      idle_on = ($urandom_range(0, 3) != 0);
      phase_len = $urandom_range(60, 200);
      if (phase_len > ITEMS_TOTAL - LAST_STRETCH - steps_queued) begin
        phase_len = ITEMS_TOTAL - LAST_STRETCH - steps_queued;
      end
      random_phase(phase_len);
      if (phase_no == 1) begin
        hold_go = 1'b1;
      end
      phase_no++;
      wait_idle();
    end

    // Closing stretch at full rate on both sides
    idle_on = 1'b0;
    random_phase(LAST_STRETCH);
    wait_idle();
    repeat (SETTLE_CYCLES) @(posedge clk_i);

    $display("Summary: %0d control steps, %0d drive beats checked over %0d register settings",
             steps_taken, drives_seen, settings_used);
    $display("  (short and long steps, saturating gains, zero limits, %0d-cycle output hold)",
             HOLD_CYCLES);
    if (bad_drive == 0 && expected_drive.size() == 0) begin
      $display("testbench OK");
    end else begin
      $display("testbench NOT OK");
    end
    $finish;
  end

endmodule
